FILE: hdl/rgb_pixel_histogram_macros.svh
// Assertion macros used by the checker of the pixel histogram.
// No dependencies; included by the checker file.
`ifndef RGB_PIXEL_HISTOGRAM_MACROS_SVH
`define RGB_PIXEL_HISTOGRAM_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RPH_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgb_pixel_histogram check failed");

// Next-cycle implication, disabled while reset is high.
`define RPH_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgb_pixel_histogram check failed");

`endif

FILE: hdl/rph_pkg.sv
// Shared types and constants of the RGB pixel histogram.
// No dependencies; imported by every module of the block.
package rph_pkg;

  localparam int LEVEL_W = 8;
  localparam int OUT_W   = 32;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET = 8'd255;

  // Control that goes from the top level to each channel lane.
  typedef struct packed {
    logic clr;  // clearing pass writes zero at the sweep address
    logic acc;  // a transaction is accepted in this cycle
    logic inc;  // the accepted transaction is a pixel
  } lane_ctl_t;

  // Control that goes from the top level to the result stage.
  typedef struct packed {
    logic rd;    // a registered read acceptance: the lane counts of the read are valid
    logic zero;  // the read bin lies above the top bin
  } merge_ctl_t;

endpackage

FILE: hdl/rph_lane.sv
// One channel lane: a bin memory with a saturating read-modify-write.
// Depends on rph_pkg; instantiated three times by rgb_pixel_histogram.
module rph_lane #(
  parameter int LEVELS     = 256,
  parameter int COUNT_BITS = 32,
  parameter int IDX_W      = $clog2(LEVELS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rph_pkg::lane_ctl_t    ctl,
  input  logic [IDX_W-1:0]      addr,
  input  logic [IDX_W-1:0]      clr_addr,
  output logic [COUNT_BITS-1:0] count
);
  import rph_pkg::*;

  logic [COUNT_BITS-1:0] mem [LEVELS];
  logic [COUNT_BITS-1:0] rd_data;
  logic                  s1_inc;
  logic [IDX_W-1:0]      s1_addr;
  logic                  fwd_valid;
  logic [IDX_W-1:0]      fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;
  logic [COUNT_BITS-1:0] inc_data;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  // The memory read returns the value before the write of the previous
  // transaction, so the last written bin is forwarded.
  assign count    = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rd_data;
  assign inc_data = (count == {COUNT_BITS{1'b1}}) ? count : count + COUNT_BITS'(1);

  assign wr_en   = ctl.clr | s1_inc;
  assign wr_addr = ctl.clr ? clr_addr : s1_addr;
  assign wr_data = ctl.clr ? '0 : inc_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.acc) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_inc    <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_inc <= ctl.acc & ctl.inc;
      if (s1_inc) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      s1_addr <= addr;
    end
    if (s1_inc) begin
      fwd_addr <= s1_addr;
      fwd_data <= inc_data;
    end
  end

endmodule

FILE: hdl/rph_merge.sv
// Result stage: gathers the three lane counts into one registered result.
// Depends on rph_pkg; instantiated by rgb_pixel_histogram.
module rph_merge #(
  parameter int COUNT_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rph_pkg::merge_ctl_t            ctl,
  input  logic [rph_pkg::LEVEL_W-1:0]    bin_in,
  input  logic [COUNT_BITS-1:0]          red_in,
  input  logic [COUNT_BITS-1:0]          green_in,
  input  logic [COUNT_BITS-1:0]          blue_in,
  output logic                           result_valid,
  output logic [rph_pkg::LEVEL_W-1:0]    bin_echo,
  output logic [rph_pkg::OUT_W-1:0]      red_count,
  output logic [rph_pkg::OUT_W-1:0]      green_count,
  output logic [rph_pkg::OUT_W-1:0]      blue_count
);
  import rph_pkg::*;

  localparam int EXT_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

  // Counts above the largest value of the result field are reported saturated.
  function automatic logic [OUT_W-1:0] report(input logic [COUNT_BITS-1:0] c);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(c);
    return (ext > EXT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : ext[OUT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      bin_echo    <= bin_in;
      red_count   <= ctl.zero ? '0 : report(red_in);
      green_count <= ctl.zero ? '0 : report(green_in);
      blue_count  <= ctl.zero ? '0 : report(blue_in);
    end
  end

endmodule

FILE: hdl/rgb_pixel_histogram.sv
// Per-channel intensity histograms of an RGB pixel stream.
// Depends on rph_pkg, rph_lane and rph_merge.
//
// A transaction is accepted at a clock edge with start high and busy low.
// req_type selects a pixel (count red_level, green_level and blue_level in
// their bins, no result) or a read (report the three counts of bin_index).
// Levels above max_level are counted in the top bin; reads above it report
// zero counts. Counters saturate at their largest value.
// Throughput is one transaction per cycle while busy is low: each of the three
// lanes does a read-modify-write, and the bin written last is forwarded
// to the following transaction.
// A read result is on the result ports for one cycle with result_valid high,
// after the lane read register and then the result register of rph_merge, and
// is taken while result_valid is high. The receiver cannot stall.
// max_level is written through cfg_we/cfg_data; the user must do so only while
// no transaction is in flight, which the block does not enforce. Resets to 255.
// After reset a clearing pass zeroes the bin memories, one bin per cycle from
// bin 0 up to bin LEVELS-1, and busy stays high until it is done.
module rgb_pixel_histogram #(
  parameter int LEVELS     = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type,
  input  logic [rph_pkg::LEVEL_W-1:0] red_level,
  input  logic [rph_pkg::LEVEL_W-1:0] green_level,
  input  logic [rph_pkg::LEVEL_W-1:0] blue_level,
  input  logic [rph_pkg::LEVEL_W-1:0] bin_index,
  input  logic                        cfg_we,
  input  logic [rph_pkg::LEVEL_W-1:0] cfg_data,
  output logic                        result_valid,
  output logic [rph_pkg::LEVEL_W-1:0] bin_echo,
  output logic [rph_pkg::OUT_W-1:0]   red_count,
  output logic [rph_pkg::OUT_W-1:0]   green_count,
  output logic [rph_pkg::OUT_W-1:0]   blue_count
);
  import rph_pkg::*;

  localparam int IDX_W = $clog2(LEVELS);
  localparam int CMP_W = (IDX_W > LEVEL_W) ? IDX_W : LEVEL_W;

  logic [LEVEL_W-1:0]    max_level;
  logic                  clr_busy;
  logic [IDX_W-1:0]      clr_addr;
  logic [CMP_W-1:0]      max_wide;
  logic [CMP_W-1:0]      top_bin;
  logic                  acc;
  logic                  is_pixel;
  lane_ctl_t             lane_ctl;
  merge_ctl_t            merge_ctl;
  logic [IDX_W-1:0]      red_addr;
  logic [IDX_W-1:0]      green_addr;
  logic [IDX_W-1:0]      blue_addr;
  logic [IDX_W-1:0]      rd_addr;
  logic                  s1_rd;
  logic                  s1_zero;
  logic [LEVEL_W-1:0]    s1_bin;
  logic [COUNT_BITS-1:0] red_cnt;
  logic [COUNT_BITS-1:0] green_cnt;
  logic [COUNT_BITS-1:0] blue_cnt;

  function automatic logic [IDX_W-1:0] clamp_bin(input logic [LEVEL_W-1:0] lvl,
                                                 input logic [CMP_W-1:0]   top);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(lvl);
    return (wide > top) ? IDX_W'(top) : IDX_W'(wide);
  endfunction

  assign busy = clr_busy | rst;
  assign acc  = start & ~busy;
  assign is_pixel = (req_type == REQ_PIXEL);

  // The top bin is the configured level, limited to the memory depth.
  assign max_wide = CMP_W'(max_level);
  assign top_bin  = (max_wide > CMP_W'(LEVELS - 1)) ? CMP_W'(LEVELS - 1) : max_wide;

  assign rd_addr    = IDX_W'(bin_index);
  assign red_addr   = is_pixel ? clamp_bin(red_level, top_bin)   : rd_addr;
  assign green_addr = is_pixel ? clamp_bin(green_level, top_bin) : rd_addr;
  assign blue_addr  = is_pixel ? clamp_bin(blue_level, top_bin)  : rd_addr;

  assign lane_ctl.clr = clr_busy;
  assign lane_ctl.acc = acc;
  assign lane_ctl.inc = is_pixel;

  assign merge_ctl.rd   = s1_rd;
  assign merge_ctl.zero = s1_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_level <= MAX_LEVEL_RESET;
    end else if (cfg_we) begin
      max_level <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + IDX_W'(1);
      if (clr_addr == IDX_W'(LEVELS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_rd <= 1'b0;
    end else begin
      s1_rd <= acc & ~is_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_bin  <= bin_index;
      s1_zero <= CMP_W'(bin_index) > top_bin;
    end
  end

  rph_lane #(
    .LEVELS     (LEVELS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_red_lane (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lane_ctl),
    .addr     (red_addr),
    .clr_addr (clr_addr),
    .count    (red_cnt)
  );

  rph_lane #(
    .LEVELS     (LEVELS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_green_lane (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lane_ctl),
    .addr     (green_addr),
    .clr_addr (clr_addr),
    .count    (green_cnt)
  );

  rph_lane #(
    .LEVELS     (LEVELS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_blue_lane (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lane_ctl),
    .addr     (blue_addr),
    .clr_addr (clr_addr),
    .count    (blue_cnt)
  );

  rph_merge #(
    .COUNT_BITS (COUNT_BITS)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctl          (merge_ctl),
    .bin_in       (s1_bin),
    .red_in       (red_cnt),
    .green_in     (green_cnt),
    .blue_in      (blue_cnt),
    .result_valid (result_valid),
    .bin_echo     (bin_echo),
    .red_count    (red_count),
    .green_count  (green_count),
    .blue_count   (blue_count)
  );

endmodule

FILE: hdl/rph_checker.sv
// Port-level checks of the pixel histogram, bound to the top level.
// Depends on rph_pkg and rgb_pixel_histogram_macros.svh.
`include "rgb_pixel_histogram_macros.svh"

module rph_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic req_type,
  input logic result_valid
);
  import rph_pkg::*;

  logic rd_acc;

  assign rd_acc = start & ~busy & (req_type == REQ_READ);

  // Every accepted read gives exactly one result, and every result comes from an accepted read.
  `RPH_ASSERT_SAME(a_read_gives_result, clk, rst, $past(rd_acc, 2) && !$past(rst) && !$past(rst, 2), result_valid)
  `RPH_ASSERT_SAME(a_result_from_read, clk, rst, result_valid && !$past(rst) && !$past(rst, 2), $past(rd_acc, 2))
  // The clearing pass holds busy right after reset.
  `RPH_ASSERT_SAME(a_busy_after_reset, clk, rst, $past(rst), busy)
  // Once the clearing pass ends, busy stays low until the next reset.
  `RPH_ASSERT_NEXT(a_busy_only_clearing, clk, rst, !busy, !busy)

endmodule

bind rgb_pixel_histogram rph_checker u_rph_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .req_type     (req_type),
  .result_valid (result_valid)
);
